/* sv/idepc_pkg.sv */
package idepc_pkg;

    typedef enum logic [2:0] {
        CMD_IO_READ    = 3'd0,
        CMD_IO_WRITE   = 3'd1,
        CMD_AUTOMAP    = 3'd2,
        CMD_SOFT_RESET = 3'd3,
        CMD_HARD_RESET = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ACC_NONE  = 2'd0,
        ACC_READ  = 2'd1,
        ACC_WRITE = 2'd2
    } access_t;

    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_WP     = 1'b1;

    localparam logic [7:0] IDE_PORT_MASK  = 8'hE3;
    localparam logic [7:0] IDE_PORT_MATCH = 8'hA3;
    localparam logic [7:0] CTRL_PORT      = 8'hE3;
    localparam int         CONMEM_BIT     = 7;
    localparam int         MAPRAM_BIT     = 6;
    localparam logic [7:0] CTRL_MAPRAM    = 8'h40;

    localparam int IN_W  = 32;
    localparam int OUT_W = 24;

    typedef struct packed {
        logic        automap_level;
        logic [7:0]  data;
        logic [15:0] port;
        logic [2:0]  cmd;
    } in_item_t;

    typedef struct packed {
        logic        high_bank_writable;
        logic [1:0]  high_bank_page;
        logic        low_bank_writable;
        logic        low_bank_source;
        logic        paged_in;
        logic        unclaimed_read;
        logic [7:0]  ide_wdata;
        logic [2:0]  ide_reg;
        logic [1:0]  ide_access;
    } out_item_t;

    typedef struct packed {
        logic       we;
        logic       index;
        logic       data;
    } cfg_wr_t;

    function automatic logic paging(input logic [7:0] ctrl, input logic automap,
                                    input logic wp);
        paging = ctrl[CONMEM_BIT] | (automap & (wp | ctrl[MAPRAM_BIT]));
    endfunction

endpackage

/* sv/idepc_engine.sv */
module idepc_engine #(
    parameter int PAGE_W = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  idepc_pkg::cfg_wr_t  cfg,
    input  logic                step,
    input  idepc_pkg::in_item_t item,
    output idepc_pkg::out_item_t result
);
    import idepc_pkg::*;

    logic       enabled_reg;
    logic       wp_reg;
    logic [7:0] ctrl_reg;
    logic [7:0] ctrl_next;
    logic       automap_reg;
    logic       automap_next;
    logic       active_reg;
    logic       active_next;

    logic              ide_port;
    logic              ctrl_port;
    logic [PAGE_W-1:0] page;

    assign ide_port  = (item.port[7:0] & IDE_PORT_MASK) == IDE_PORT_MATCH;
    assign ctrl_port = item.port[7:0] == CTRL_PORT;

    always_comb
    begin
        ctrl_next    = ctrl_reg;
        automap_next = automap_reg;
        active_next  = active_reg;
        result       = '0;
        case (cmd_t'(item.cmd))
            CMD_IO_READ:
            begin
                if (ide_port)
                begin
                    result.ide_reg        = item.port[4:2];
                    result.ide_access     = enabled_reg ? ACC_READ : ACC_NONE;
                    result.unclaimed_read = !enabled_reg;
                end
            end
            CMD_IO_WRITE:
            begin
                if (enabled_reg && ide_port)
                begin
                    result.ide_access = ACC_WRITE;
                    result.ide_reg    = item.port[4:2];
                    result.ide_wdata  = item.data;
                end
                if (enabled_reg && ctrl_port)
                begin
                    ctrl_next   = item.data | (ctrl_reg & CTRL_MAPRAM);
                    active_next = paging(ctrl_next, automap_reg, wp_reg);
                end
            end
            CMD_AUTOMAP:
            begin
                automap_next = item.automap_level;
                active_next  = paging(ctrl_reg, item.automap_level, wp_reg);
            end
            CMD_SOFT_RESET, CMD_HARD_RESET:
            begin
                active_next = 1'b0;
                if (enabled_reg)
                begin
                    ctrl_next    = (item.cmd == CMD_HARD_RESET) ? 8'h00
                                                                : (ctrl_reg & CTRL_MAPRAM);
                    automap_next = 1'b0;
                    active_next  = paging(ctrl_next, 1'b0, wp_reg);
                end
            end
            default:
            begin
            end
        endcase

        // bank selection follows the state after the item
        page            = ctrl_next[PAGE_W-1:0];
        result.paged_in = active_next;
        if (active_next)
        begin
            result.high_bank_page = page[1:0];
            if (ctrl_next[CONMEM_BIT])
            begin
                result.low_bank_writable  = !wp_reg;
                result.high_bank_writable = 1'b1;
            end
            else if (ctrl_next[MAPRAM_BIT])
            begin
                result.low_bank_source    = 1'b1;
                result.high_bank_writable = page != PAGE_W'(3);
            end
            else
            begin
                result.high_bank_writable = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b1;
            wp_reg      <= 1'b0;
            ctrl_reg    <= 8'h00;
            automap_reg <= 1'b0;
            active_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.we && cfg.index == CFG_ENABLE)
                enabled_reg <= cfg.data;
            if (cfg.we && cfg.index == CFG_WP)
                wp_reg <= cfg.data;
            if (step)
            begin
                ctrl_reg    <= ctrl_next;
                automap_reg <= automap_next;
                active_reg  <= active_next;
            end
        end
    end

endmodule

/* sv/ide_interface_paging_control_core.sv */
// an accepted item is decoded between two register stages, the input and result registers
// throughput: one item per cycle unless m_tready stalls, from the single decode/paging stage
// an input register feeds the decode stage, a result register holds the output item
// reset: rst_n asynchronous active low; interface enabled, write protect off,
// control byte, automap and paging cleared, both pipeline stages empty
module ide_interface_paging_control_core #(
    parameter int RAM_PAGES = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic                        cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // cmd[2:0], port[18:3], data[26:19], automap_level[27], zero[31:28]
    input  logic [idepc_pkg::IN_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // ide_access[1:0], ide_reg[4:2], ide_wdata[12:5], unclaimed_read[13],
    // paged_in[14], low_bank_source[15], low_bank_writable[16],
    // high_bank_page[18:17], high_bank_writable[19], zero[23:20]
    output logic [idepc_pkg::OUT_W-1:0] m_tdata
);
    import idepc_pkg::*;

    localparam int PAGE_W = $clog2(RAM_PAGES);

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t result;
    cfg_wr_t   cfg;
    logic      advance;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    idepc_engine #(
        .PAGE_W (PAGE_W)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (in_valid_reg && advance),
        .item   (in_item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_item_reg <= in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
        if (in_valid_reg && advance)
            out_item_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - $bits(out_item_t)){1'b0}}, out_item_reg};

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    a_unclaimed_no_access: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_item_reg.unclaimed_read |-> out_item_reg.ide_access == ACC_NONE)
        else $error("unclaimed read reported as an access");

    a_banks_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !out_item_reg.paged_in |->
            out_item_reg.high_bank_page == 2'd0 && !out_item_reg.low_bank_source
            && !out_item_reg.low_bank_writable && !out_item_reg.high_bank_writable)
        else $error("bank fields set while paged out");

    a_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && advance |=> out_valid_reg)
        else $error("item lost between stages");
`endif

endmodule

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import idepc_pkg::*;

    localparam int RAM_PAGES = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int BLOCKS = 8;
    localparam int ITEMS_PER_BLOCK = 250;
    localparam int OUT_FIELDS_W = $bits(out_item_t);
    localparam int IN_FIELDS_W = $bits(in_item_t);

    // command codes outside the defined set
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    class paging_tracker;
        bit enabled;
        bit write_protect;
        logic [7:0] control;
        bit automap;
        bit active;
        out_item_t pending_decodes[$];
        int errors;

        function new();
            enabled = 1'b1;
            write_protect = 1'b0;
            control = '0;
            automap = 1'b0;
            active = 1'b0;
            errors = 0;
        endfunction

        function void set_register(logic idx, logic val);
            if (idx == CFG_ENABLE)
                enabled = val;
            else
                write_protect = val;
        endfunction

        function void refresh();
            if (control[CONMEM_BIT])
                active = 1'b1;
            else if (write_protect || control[MAPRAM_BIT])
                active = automap;
            else
                active = 1'b0;
        endfunction

        function void bus_reset(bit hard);
            active = 1'b0;
            if (enabled)
            begin
                if (hard)
                    control = '0;
                else
                    control = control & CTRL_MAPRAM;
                automap = 1'b0;
                refresh();
            end
        endfunction

        function void note_bus_event(in_item_t it);
            out_item_t r;
            bit ide_hit;
            bit ctrl_hit;
            logic [7:0] page;
            r = '0;
            ide_hit = (it.port[7:0] & IDE_PORT_MASK) == IDE_PORT_MATCH;
            ctrl_hit = it.port[7:0] == CTRL_PORT;
            case (it.cmd)
                CMD_IO_READ:
                    if (ide_hit)
                    begin
                        r.ide_reg = it.port[4:2];
                        if (enabled)
                            r.ide_access = ACC_READ;
                        else
                            r.unclaimed_read = 1'b1;
                    end
                CMD_IO_WRITE:
                    if (enabled)
                    begin
                        if (ide_hit)
                        begin
                            r.ide_access = ACC_WRITE;
                            r.ide_reg = it.port[4:2];
                            r.ide_wdata = it.data;
                        end
                        if (ctrl_hit)
                        begin
                            control = it.data | (control & CTRL_MAPRAM);
                            refresh();
                        end
                    end
                CMD_AUTOMAP:
                begin
                    automap = it.automap_level;
                    refresh();
                end
                CMD_SOFT_RESET: bus_reset(1'b0);
                CMD_HARD_RESET: bus_reset(1'b1);
                default: ;
            endcase
            r.paged_in = active;
            if (active)
            begin
                page = control & 8'(RAM_PAGES - 1);
                r.high_bank_page = page[1:0];
                if (control[CONMEM_BIT])
                begin
                    r.low_bank_writable = !write_protect;
                    r.high_bank_writable = 1'b1;
                end
                else if (control[MAPRAM_BIT])
                begin
                    r.low_bank_source = 1'b1;
                    r.high_bank_writable = (page != 8'd3);
                end
                else
                    r.high_bank_writable = 1'b1;
            end
            pending_decodes.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_decodes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = pending_decodes.pop_front();
            compare_field("ide_access", want.ide_access, got.ide_access);
            compare_field("ide_reg", want.ide_reg, got.ide_reg);
            compare_field("ide_wdata", want.ide_wdata, got.ide_wdata);
            compare_field("unclaimed_read", want.unclaimed_read, got.unclaimed_read);
            compare_field("paged_in", want.paged_in, got.paged_in);
            compare_field("low_bank_source", want.low_bank_source, got.low_bank_source);
            compare_field("low_bank_writable", want.low_bank_writable, got.low_bank_writable);
            compare_field("high_bank_page", want.high_bank_page, got.high_bank_page);
            compare_field("high_bank_writable", want.high_bank_writable,
                          got.high_bank_writable);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = CFG_ENABLE;
    logic cfg_data = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    paging_tracker tracker = new();
    int send_idle_pct = 23;
    int recv_idle_pct = 74;
    int cycle_count = 0;

    ide_interface_paging_control_core #(
        .RAM_PAGES(RAM_PAGES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #1 clk = ~clk;

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                tracker.note_bus_event(in_item_t'(s_tdata[IN_FIELDS_W-1:0]));
            if (m_tvalid && m_tready)
                tracker.check_result(out_item_t'(m_tdata[OUT_FIELDS_W-1:0]));
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** ide_interface_paging_control_core: FAILED **");
            $finish;
        end
    end

    task automatic send_event(in_item_t it);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_W'(it);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending_decodes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic idx, logic val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        tracker.set_register(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic in_item_t make_event(logic [2:0] cmd, logic [15:0] port,
                                            logic [7:0] data, logic level);
        in_item_t it;
        it.cmd = cmd;
        it.port = port;
        it.data = data;
        it.automap_level = level;
        return it;
    endfunction

    function automatic in_item_t random_bus_event();
        in_item_t it;
        int unsigned roll;
        it.port = 16'($urandom);
        it.data = 8'($urandom);
        it.automap_level = 1'($urandom);
        it.cmd = CMD_IO_READ;
        roll = $urandom_range(99);
        if (roll < 25)
            it.port[7:0] = (it.port[7:0] & ~IDE_PORT_MASK) | IDE_PORT_MATCH;
        else if (roll < 45)
        begin
            it.cmd = CMD_IO_WRITE;
            it.port[7:0] = (it.port[7:0] & ~IDE_PORT_MASK) | IDE_PORT_MATCH;
        end
        else if (roll < 60)
        begin
            it.cmd = CMD_IO_WRITE;
            it.port[7:0] = CTRL_PORT;
        end
        else if (roll < 75)
            it.cmd = CMD_AUTOMAP;
        else if (roll < 85)
            it.cmd = $urandom_range(1) ? CMD_IO_WRITE : CMD_IO_READ;
        else if (roll < 90)
            it.cmd = CMD_SOFT_RESET;
        else if (roll < 95)
            it.cmd = CMD_HARD_RESET;
        else if (roll < 98)
            it.port[7:0] = CTRL_PORT;
        else
            it.cmd = 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
        return it;
    endfunction

    initial
    begin
        static bit block_enable[BLOCKS] = '{1, 1, 0, 1, 0, 1, 1, 1};
        static bit block_wp[BLOCKS] = '{0, 1, 1, 0, 0, 1, 0, 1};

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // enabled: decode extremes, paging paths, sticky map-ram
        send_event(make_event(CMD_IO_READ, 16'h00a3, 8'h00, 1'b0));
        send_event(make_event(CMD_IO_READ, 16'hffbf, 8'hff, 1'b1));
        send_event(make_event(CMD_IO_WRITE, 16'h00a3, 8'h00, 1'b0));
        send_event(make_event(CMD_IO_WRITE, 16'hffbf, 8'hff, 1'b1));
        send_event(make_event(CMD_IO_READ, 16'h00e3, 8'h00, 1'b0));
        send_event(make_event(CMD_IO_READ, 16'h1234, 8'h00, 1'b0));
        send_event(make_event(CMD_AUTOMAP, 16'h0000, 8'h00, 1'b1));
        send_event(make_event(CMD_IO_WRITE, 16'hffe3, 8'h80, 1'b0));
        send_event(make_event(CMD_IO_WRITE, 16'h00e3, 8'h03, 1'b0));
        send_event(make_event(CMD_IO_WRITE, 16'h12e3, 8'h43, 1'b0));
        send_event(make_event(CMD_IO_WRITE, 16'h00e3, 8'h00, 1'b0));
        send_event(make_event(CMD_IO_WRITE, 16'h00e3, 8'h81, 1'b0));
        send_event(make_event(CMD_SOFT_RESET, 16'h0000, 8'h00, 1'b0));
        send_event(make_event(CMD_AUTOMAP, 16'hffff, 8'hff, 1'b1));
        send_event(make_event(CMD_IO_WRITE, 16'h00e3, 8'h02, 1'b0));
        send_event(make_event(CMD_UNUSED_LO, 16'h00a3, 8'h55, 1'b0));
        send_event(make_event(CMD_UNUSED_HI, 16'h00e3, 8'haa, 1'b1));
        send_event(make_event(CMD_HARD_RESET, 16'h0000, 8'h00, 1'b0));

        // jumper flip without refresh, then disabled behavior
        send_event(make_event(CMD_IO_WRITE, 16'h00e3, 8'h80, 1'b0));
        write_register(CFG_WP, 1'b1);
        send_event(make_event(CMD_IO_READ, 16'h0000, 8'h00, 1'b0));
        write_register(CFG_ENABLE, 1'b0);
        send_event(make_event(CMD_IO_READ, 16'h00bf, 8'h00, 1'b0));
        send_event(make_event(CMD_IO_WRITE, 16'h00a3, 8'h5a, 1'b0));
        send_event(make_event(CMD_IO_WRITE, 16'h00e3, 8'h00, 1'b0));
        send_event(make_event(CMD_AUTOMAP, 16'h0000, 8'h00, 1'b1));
        send_event(make_event(CMD_SOFT_RESET, 16'h0000, 8'h00, 1'b0));
        send_event(make_event(CMD_HARD_RESET, 16'h0000, 8'h00, 1'b0));

        for (int b = 0; b < BLOCKS; b++)
        begin
            write_register(CFG_ENABLE, block_enable[b]);
            write_register(CFG_WP, block_wp[b]);
            if (b < 3)
            begin
                send_idle_pct = 23;
                recv_idle_pct = 74;
            end
            else if (b < 6)
            begin
                send_idle_pct = 74;
                recv_idle_pct = 23;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < ITEMS_PER_BLOCK; n++)
                send_event(random_bus_event());
        end

        drain();
        if (tracker.pending_decodes.size() != 0)
            $display("%0t: %0d results never arrived", $time,
                     tracker.pending_decodes.size());
        if (tracker.errors == 0 && tracker.pending_decodes.size() == 0)
            $display("** ide_interface_paging_control_core: PASSED **");
        else
            $display("** ide_interface_paging_control_core: FAILED **");
        $finish;
    end

endmodule
